[rtl/rlt_pkg.sv]
// Shared constants, codes and types for the route learning table.
package rlt_pkg;

  // Table geometry
  localparam int DEPTH   = 16;
  localparam int ID_BITS = 16;
  localparam int MAX_RES = 16;
  localparam int AW      = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int RM_W    = $clog2(MAX_RES + 1);

  // Fixed field widths
  localparam int ID_W  = 16;
  localparam int HOP_W = 8;
  localparam int TM_W  = 32;

  localparam logic [32:0] ID_MASK_WIDE = (33'd1 << ID_BITS) - 33'd1;
  localparam logic [ID_W-1:0] ID_MASK  = ID_MASK_WIDE[ID_W-1:0];

  localparam logic [TM_W-1:0] TTL_RESET = 32'd1000;

  // Action codes
  localparam logic [2:0] ACT_LEARN  = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_TICK   = 3'd2;
  localparam logic [2:0] ACT_SYNC   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // Result event codes
  localparam logic [2:0] EV_ADDED     = 3'd0;
  localparam logic [2:0] EV_UPDATED   = 3'd1;
  localparam logic [2:0] EV_REMOVED   = 3'd2;
  localparam logic [2:0] EV_FOUND     = 3'd3;
  localparam logic [2:0] EV_NOT_FOUND = 3'd4;
  localparam logic [2:0] EV_FULL      = 3'd5;
  localparam logic [2:0] EV_UNCHANGED = 3'd6;
  localparam logic [2:0] EV_DONE      = 3'd7;

  // One stored route
  typedef struct packed {
    logic [ID_W-1:0]  dest;
    logic [ID_W-1:0]  transit;
    logic [HOP_W-1:0] hops;
    logic [TM_W-1:0]  expiry;
  } entry_t;

  // Write request into the entry memory
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    entry_t        data;
  } ram_wr_t;

  // Read request into the entry memory
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
  } ram_rd_t;

  // One result word
  typedef struct packed {
    logic [2:0] ev;
    entry_t     ent;
    logic       last;
  } result_t;

endpackage

[rtl/rlt_entry_ram.sv]
// Entry memory: one write port, one registered read port.
module rlt_entry_ram (
  input  logic             clk,
  input  rlt_pkg::ram_wr_t wr,
  input  rlt_pkg::ram_rd_t rd,
  output rlt_pkg::entry_t  rd_data
);
  import rlt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/rlt_ctrl.sv]
// Sequencer: scans the entry memory, keeps valid marks, forms results.
module rlt_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               action,
  input  logic [rlt_pkg::ID_W-1:0]  dest_id,
  input  logic [rlt_pkg::ID_W-1:0]  transit_id,
  input  logic [rlt_pkg::HOP_W-1:0] hop_count,
  input  logic [rlt_pkg::TM_W-1:0]  now_ticks,
  input  logic [rlt_pkg::TM_W-1:0]  expiry_time,
  output rlt_pkg::ram_wr_t         ram_wr,
  output rlt_pkg::ram_rd_t         ram_rd,
  input  rlt_pkg::entry_t          ram_rd_data,
  output logic                     res_strobe,
  output rlt_pkg::result_t         res
);
  import rlt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Control state
  logic [1:0]       state_r, state_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             found_r, found_nxt;
  logic             free_r, free_nxt;
  logic             held_r, held_nxt;
  logic [RM_W-1:0]  rm_cnt_r, rm_cnt_nxt;
  logic             res_strobe_r, res_strobe_nxt;

  // Payload
  logic [2:0]       op_r, op_nxt;
  logic [ID_W-1:0]  dest_r, dest_nxt;
  logic [ID_W-1:0]  trans_r, trans_nxt;
  logic [HOP_W-1:0] hop_r, hop_nxt;
  logic [AW-1:0]    cmp_slot_r, cmp_slot_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]    free_slot_r, free_slot_nxt;
  entry_t           ent_r, ent_nxt;
  entry_t           held_ent_r, held_ent_nxt;
  result_t          res_r, res_nxt;

  logic             hit;
  logic             expired;
  logic             last_slot;
  entry_t           upd_ent;

  assign busy = (state_r != ST_IDLE);

  // Compare terms for the word coming back from memory
  assign hit       = valid_r[cmp_slot_r] && (ram_rd_data.dest == dest_r);
  assign expired   = valid_r[cmp_slot_r] && (ram_rd_data.expiry <= now_ticks)
                     && (rm_cnt_r < RM_W'(MAX_RES));
  assign last_slot = (cmp_slot_r == AW'(DEPTH - 1));

  // Route written by a learn
  always_comb begin
    upd_ent.dest    = found_r ? ent_r.dest : dest_r;
    upd_ent.transit = trans_r;
    upd_ent.hops    = hop_r;
    upd_ent.expiry  = expiry_time;
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = 1'b0;
    found_nxt      = found_r;
    free_nxt       = free_r;
    held_nxt       = held_r;
    rm_cnt_nxt     = rm_cnt_r;
    op_nxt         = op_r;
    dest_nxt       = dest_r;
    trans_nxt      = trans_r;
    hop_nxt        = hop_r;
    cmp_slot_nxt   = cmp_slot_r;
    slot_nxt       = slot_r;
    free_slot_nxt  = free_slot_r;
    ent_nxt        = ent_r;
    held_ent_nxt   = held_ent_r;
    res_strobe_nxt = 1'b0;
    res_nxt        = res_r;
    ram_wr         = '0;
    ram_rd         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = action;
          dest_nxt  = dest_id & ID_MASK;
          trans_nxt = transit_id & ID_MASK;
          hop_nxt   = hop_count;
          case (action)
            ACT_LEARN, ACT_LOOKUP, ACT_SYNC: begin
              // first read goes out with the accept
              ram_rd.en    = 1'b1;
              ram_rd.addr  = '0;
              cmp_vld_nxt  = 1'b1;
              cmp_slot_nxt = '0;
              rd_cnt_nxt   = CNT_W'(1);
              found_nxt    = 1'b0;
              free_nxt     = 1'b0;
              held_nxt     = 1'b0;
              rm_cnt_nxt   = '0;
              state_nxt    = ST_SCAN;
            end
            ACT_CLEAR: begin
              valid_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue the next read
        if (rd_cnt_r < CNT_W'(DEPTH)) begin
          ram_rd.en    = 1'b1;
          ram_rd.addr  = rd_cnt_r[AW-1:0];
          cmp_vld_nxt  = 1'b1;
          cmp_slot_nxt = rd_cnt_r[AW-1:0];
          rd_cnt_nxt   = rd_cnt_r + CNT_W'(1);
        end
        // examine the returned word
        if (cmp_vld_r) begin
          if (op_r == ACT_SYNC) begin
            if (expired) begin
              valid_nxt[cmp_slot_r] = 1'b0;
              rm_cnt_nxt            = rm_cnt_r + RM_W'(1);
              held_nxt              = 1'b1;
              held_ent_nxt          = ram_rd_data;
              // an earlier removal is now known not to be the last
              if (held_r) begin
                res_strobe_nxt = 1'b1;
                res_nxt.ev     = EV_REMOVED;
                res_nxt.ent    = held_ent_r;
                res_nxt.last   = 1'b0;
              end
            end
          end else begin
            if (hit && !found_r) begin
              found_nxt = 1'b1;
              slot_nxt  = cmp_slot_r;
              ent_nxt   = ram_rd_data;
            end
            if (!valid_r[cmp_slot_r] && !free_r) begin
              free_nxt      = 1'b1;
              free_slot_nxt = cmp_slot_r;
            end
          end
          if (last_slot) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        state_nxt      = ST_IDLE;
        res_strobe_nxt = 1'b1;
        res_nxt.last   = 1'b1;
        case (op_r)
          ACT_LEARN: begin
            if (found_r) begin
              if (ent_r.hops >= hop_r) begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = slot_r;
                ram_wr.data = upd_ent;
                res_nxt.ev  = EV_UPDATED;
                res_nxt.ent = upd_ent;
              end else begin
                res_nxt.ev  = EV_UNCHANGED;
                res_nxt.ent = ent_r;
              end
            end else if (free_r) begin
              ram_wr.en              = 1'b1;
              ram_wr.addr            = free_slot_r;
              ram_wr.data            = upd_ent;
              valid_nxt[free_slot_r] = 1'b1;
              res_nxt.ev             = EV_ADDED;
              res_nxt.ent            = upd_ent;
            end else begin
              res_nxt.ev          = EV_FULL;
              res_nxt.ent.dest    = dest_r;
              res_nxt.ent.transit = trans_r;
              res_nxt.ent.hops    = hop_r;
              res_nxt.ent.expiry  = '0;
            end
          end
          ACT_LOOKUP: begin
            if (found_r) begin
              res_nxt.ev  = EV_FOUND;
              res_nxt.ent = ent_r;
            end else begin
              res_nxt.ev          = EV_NOT_FOUND;
              res_nxt.ent.dest    = dest_r;
              res_nxt.ent.transit = '0;
              res_nxt.ent.hops    = '0;
              res_nxt.ent.expiry  = '0;
            end
          end
          default: begin
            // synchronize: flush the held removal or report none
            if (held_r) begin
              res_nxt.ev  = EV_REMOVED;
              res_nxt.ent = held_ent_r;
            end else begin
              res_nxt.ev          = EV_DONE;
              res_nxt.ent.dest    = '0;
              res_nxt.ent.transit = '0;
              res_nxt.ent.hops    = '0;
              res_nxt.ent.expiry  = now_ticks;
            end
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      rd_cnt_r     <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_r       <= 1'b0;
      held_r       <= 1'b0;
      rm_cnt_r     <= '0;
      res_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      found_r      <= found_nxt;
      free_r       <= free_nxt;
      held_r       <= held_nxt;
      rm_cnt_r     <= rm_cnt_nxt;
      res_strobe_r <= res_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    dest_r      <= dest_nxt;
    trans_r     <= trans_nxt;
    hop_r       <= hop_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    slot_r      <= slot_nxt;
    free_slot_r <= free_slot_nxt;
    ent_r       <= ent_nxt;
    held_ent_r  <= held_ent_nxt;
    res_r       <= res_nxt;
  end

  assign res_strobe = res_strobe_r;
  assign res        = res_r;

endmodule

[rtl/route_learning_table.sv]
// Top level of the route learning table: time base, TTL register, memory and sequencer.
//
// Input: an action word is taken at a rising edge with start high and busy low.
//   Learn, lookup and synchronize scan all DEPTH slots of the entry memory, one
//   slot a cycle through its single read port; busy stays high through the scan
//   and the result step, and the next word can follow in the cycle busy drops.
//   Tick and clear finish in the accept cycle and leave busy low.
// Output: each result word stands on the out_ ports for one cycle with
//   out_strobe high; the receiver cannot hold results off. Learn and lookup
//   give one result, in the cycle busy drops. Synchronize reports each
//   removal while it scans, once the next expired slot is found; its final
//   word (out_last high) comes in the cycle busy drops.
// Configuration: cfg_we writes cfg_wdata into the route TTL; write it only
//   while busy is low and no result is pending.
// Reset (rst_n low, synchronous): all routes invalid, time counter zero,
//   TTL 1000. Stored route fields are not cleared; an invalid slot is never
//   reported.
module route_learning_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_dest_id,
  input  logic [15:0] in_transit_id,
  input  logic [7:0]  in_hop_count,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_strobe,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_route_dest,
  output logic [15:0] out_route_transit,
  output logic [7:0]  out_route_hops,
  output logic [31:0] out_route_expiry,
  output logic        out_last
);
  import rlt_pkg::*;

  logic [TM_W-1:0] ttl_r, ttl_nxt;
  logic [TM_W-1:0] now_r, now_nxt;
  logic [TM_W:0]   exp_sum;
  logic [TM_W-1:0] expiry_time;
  ram_wr_t         ram_wr;
  ram_rd_t         ram_rd;
  entry_t          ram_rd_data;
  result_t         res;

  // TTL register and saturating time counter
  always_comb begin
    ttl_nxt = cfg_we ? cfg_wdata : ttl_r;
    now_nxt = now_r;
    if (start && !busy && (in_action == ACT_TICK) && (now_r != '1)) begin
      now_nxt = now_r + TM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
      now_r <= '0;
    end else begin
      ttl_r <= ttl_nxt;
      now_r <= now_nxt;
    end
  end

  // Expiry of a learned route, saturating
  assign exp_sum     = {1'b0, now_r} + {1'b0, ttl_r};
  assign expiry_time = exp_sum[TM_W] ? '1 : exp_sum[TM_W-1:0];

  rlt_entry_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rd_data)
  );

  rlt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .action      (in_action),
    .dest_id     (in_dest_id),
    .transit_id  (in_transit_id),
    .hop_count   (in_hop_count),
    .now_ticks   (now_r),
    .expiry_time (expiry_time),
    .ram_wr      (ram_wr),
    .ram_rd      (ram_rd),
    .ram_rd_data (ram_rd_data),
    .res_strobe  (out_strobe),
    .res         (res)
  );

  assign out_event_res     = res.ev;
  assign out_route_dest    = res.ent.dest;
  assign out_route_transit = res.ent.transit;
  assign out_route_hops    = res.ent.hops;
  assign out_route_expiry  = res.ent.expiry;
  assign out_last          = res.last;

endmodule
